// ===== hw/rtl/kac_pkg.sv =====
// Package for the key autorepeat cursor block.
// Holds the key layout, register indexes, counter widths and the fire struct.
// No dependencies.
`timescale 1ns / 1ps

package kac_pkg;

  localparam int KEY_W     = 10;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam int OUT_POS_W = 4;
  localparam int NUM_DIR   = 4;

  // Key bit positions in the pressed-key set
  localparam int KEY_ACT_BIT   = 0;
  localparam int KEY_RIGHT_BIT = 4;
  localparam int KEY_LEFT_BIT  = 5;
  localparam int KEY_UP_BIT    = 6;
  localparam int KEY_DOWN_BIT  = 7;

  // Direction slots, in the order fires are applied
  localparam int DIR_LEFT  = 0;
  localparam int DIR_RIGHT = 1;
  localparam int DIR_UP    = 2;
  localparam int DIR_DOWN  = 3;

  localparam int DIR_KEY_BIT [NUM_DIR] = '{KEY_LEFT_BIT, KEY_RIGHT_BIT, KEY_UP_BIT,
                                            KEY_DOWN_BIT};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RATE  = 8'd1;

  localparam logic [CNT_W-1:0] RESET_DELAY = 8'd10;
  localparam logic [CNT_W-1:0] RESET_RATE  = 8'd3;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } dir_fire_t;

endpackage

// ===== hw/rtl/kac_key_if.sv =====
// Input channel of the key autorepeat cursor: one raw key register per beat.
// Depends on kac_pkg.
`timescale 1ns / 1ps

interface kac_key_if
  import kac_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_bits;

  modport source (output valid, output key_bits, input ready);
  modport sink (input valid, input key_bits, output ready);
endinterface

// ===== hw/rtl/kac_res_if.sv =====
// Result channel of the key autorepeat cursor: cursor position and flags per beat.
// Depends on kac_pkg.
`timescale 1ns / 1ps

interface kac_res_if
  import kac_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_POS_W-1:0] cursor_col;
  logic [OUT_POS_W-1:0] cursor_row;
  logic                 cursor_moved;
  logic                 action_press;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_moved, output action_press, input ready);
  modport sink (input valid, input cursor_col, input cursor_row,
                input cursor_moved, input action_press, output ready);
endinterface

// ===== hw/rtl/kac_cfg_if.sv =====
// Configuration write channel of the key autorepeat cursor: index and data.
// Depends on kac_pkg.
`timescale 1ns / 1ps

interface kac_cfg_if
  import kac_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/kac_repeat.sv =====
// Repeat counter for one direction key: press-edge fire, delay and rate reloads.
// Depends on kac_pkg.
`timescale 1ns / 1ps

module kac_repeat
  import kac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             now_key,
  input  logic             prev_key,
  input  logic [CNT_W-1:0] delay,
  input  logic [CNT_W-1:0] rate,
  output logic             fire
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    if (!now_key) begin
      cnt_next = '0;
      fire     = 1'b0;
    end else if (!prev_key) begin
      cnt_next = delay;
      fire     = 1'b1;
    end else if (cnt == '0) begin
      cnt_next = rate;
      fire     = 1'b1;
    end else begin
      cnt_next = cnt - CNT_W'(1);
      fire     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (adv) begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/kac_cursor.sv =====
// Cursor position registers and the ordered, edge-clamped move logic.
// Depends on kac_pkg (dir_fire_t).
`timescale 1ns / 1ps

module kac_cursor
  import kac_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  dir_fire_t                    fire,
  output logic [$clog2(GRID_SIZE)-1:0] col_next,
  output logic [$clog2(GRID_SIZE)-1:0] row_next,
  output logic                         moved
);

  localparam int              POS_W   = $clog2(GRID_SIZE);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(GRID_SIZE - 1);
  localparam logic [POS_W-1:0] POS_MID = POS_W'(GRID_SIZE / 2);

  logic [POS_W-1:0] pos_col;
  logic [POS_W-1:0] pos_row;
  logic [POS_W-1:0] row_a;
  logic [POS_W-1:0] col_a;
  logic             mv_left, mv_right, mv_up, mv_down;

  // Apply fires in order; each step sees the position left by the one before
  always_comb begin
    mv_left  = fire.left && (pos_row != POS_MAX);
    row_a    = mv_left ? pos_row + POS_W'(1) : pos_row;
    mv_right = fire.right && (row_a != '0);
    row_next = mv_right ? row_a - POS_W'(1) : row_a;
    mv_up    = fire.up && (pos_col != '0);
    col_a    = mv_up ? pos_col - POS_W'(1) : pos_col;
    mv_down  = fire.down && (col_a != POS_MAX);
    col_next = mv_down ? col_a + POS_W'(1) : col_a;
    moved    = mv_left | mv_right | mv_up | mv_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_col <= POS_MID;
      pos_row <= POS_MID;
    end else if (adv) begin
      pos_col <= col_next;
      pos_row <= row_next;
    end
  end

  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    (pos_col <= POS_MAX) && (pos_row <= POS_MAX))
    else $error("cursor left the grid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(pos_col) && $stable(pos_row))
    else $error("cursor moved without a tick");

  a_no_fire: assert property (@(posedge clk) disable iff (rst)
    (fire == '0) |-> !moved && (col_next == pos_col) && (row_next == pos_row))
    else $error("cursor moved with no fire");

endmodule

// ===== hw/rtl/key_autorepeat_cursor.sv =====
// Top level of the key autorepeat cursor: input register, repeat counters,
// cursor move logic and result register. Depends on kac_pkg, the kac_*_if
// interfaces, kac_repeat and kac_cursor.
`timescale 1ns / 1ps

// Channel  | Port   | Dir | Beat contents
// ---------+--------+-----+----------------------------------------------------
// input    | key    | in  | key_bits: raw key register, active low, one frame
// result   | cursor | out | cursor_col, cursor_row, cursor_moved, action_press
// config   | cfg    | in  | index (0 repeat_delay, 1 repeat_rate), data
//
// Each key beat yields exactly one result beat, via the input and then the result register.
// One beat enters per cycle while the result does not stall: the input register and
// the result register form a two-deep pipe, with combinational per-key logic between.
// Synchronous rst centers the cursor, clears key history and counters,
// and loads delay 10 and rate 3.
// A stalled result holds the pipe; the input register still takes a beat
// while the result register is full and the stage is empty.
// The config port is always ready; write it only while the block is idle.

module key_autorepeat_cursor
  import kac_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst,
  kac_key_if.sink   key,
  kac_res_if.source cursor,
  kac_cfg_if.sink   cfg
);

  localparam int POS_W = $clog2(GRID_SIZE);
  localparam int EXT_W = (POS_W > OUT_POS_W) ? POS_W : OUT_POS_W;

  logic [CNT_W-1:0] repeat_delay;
  logic [CNT_W-1:0] repeat_rate;

  logic             s1_valid;
  logic [KEY_W-1:0] s1_now;
  logic             s1_adv;
  logic             in_ready;

  logic [KEY_W-1:0] previous_keys;

  logic [NUM_DIR-1:0] fire_vec;
  dir_fire_t          fire;
  logic [POS_W-1:0]   col_next;
  logic [POS_W-1:0]   row_next;
  logic               moved;
  logic               act;
  logic [EXT_W-1:0]   col_ext;
  logic [EXT_W-1:0]   row_ext;

  logic                 res_valid;
  logic [OUT_POS_W-1:0] res_col;
  logic [OUT_POS_W-1:0] res_row;
  logic                 res_moved;
  logic                 res_act;

  // Configuration registers; indexes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= RESET_DELAY;
      repeat_rate  <= RESET_RATE;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_REPEAT_DELAY) begin
        repeat_delay <= CNT_W'(cfg.data);
      end else if (cfg.index == CFG_REPEAT_RATE) begin
        repeat_rate <= CNT_W'(cfg.data);
      end
    end
  end

  // Stage 1: advance into the result register whenever it is free or draining
  assign s1_adv   = s1_valid && (!res_valid || cursor.ready);
  assign in_ready = !s1_valid || s1_adv;
  assign key.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= key.valid;
    end
  end

  // Invert the active-low key register into the pressed-key set
  always_ff @(posedge clk) begin
    if (key.valid && in_ready) begin
      s1_now <= ~key.key_bits;
    end
  end

  // Key history for press edges
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
    end else if (s1_adv) begin
      previous_keys <= s1_now;
    end
  end

  // One repeat counter per direction key
  for (genvar d = 0; d < NUM_DIR; d++) begin : g_dir
    kac_repeat u_repeat (
      .clk      (clk),
      .rst      (rst),
      .adv      (s1_adv),
      .now_key  (s1_now[DIR_KEY_BIT[d]]),
      .prev_key (previous_keys[DIR_KEY_BIT[d]]),
      .delay    (repeat_delay),
      .rate     (repeat_rate),
      .fire     (fire_vec[d])
    );
  end

  assign fire.left  = fire_vec[DIR_LEFT];
  assign fire.right = fire_vec[DIR_RIGHT];
  assign fire.up    = fire_vec[DIR_UP];
  assign fire.down  = fire_vec[DIR_DOWN];

  kac_cursor #(
    .GRID_SIZE (GRID_SIZE)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .fire     (fire),
    .col_next (col_next),
    .row_next (row_next),
    .moved    (moved)
  );

  assign act = s1_now[KEY_ACT_BIT] && !previous_keys[KEY_ACT_BIT];

  // The result carries the low bits of the position; a narrow grid zero-extends
  assign col_ext = EXT_W'(col_next);
  assign row_ext = EXT_W'(row_next);

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (cursor.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_col   <= col_ext[OUT_POS_W-1:0];
      res_row   <= row_ext[OUT_POS_W-1:0];
      res_moved <= moved;
      res_act   <= act;
    end
  end

  assign cursor.valid        = res_valid;
  assign cursor.cursor_col   = res_col;
  assign cursor.cursor_row   = res_row;
  assign cursor.cursor_moved = res_moved;
  assign cursor.action_press = res_act;

  a_adv_loads: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("advanced beat did not reach the result register");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && res_valid && !cursor.ready)
    else $error("input stalled while the pipe could move");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    res_valid && !cursor.ready |=> res_valid)
    else $error("pending result dropped");

endmodule
